/* design/wsd_pkg.sv */
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types, constants and helpers for the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

	// length codes carried in the low seven bits of the info byte
	parameter logic [6:0] LenCode16 = 7'd126;
	parameter logic [6:0] LenCode64 = 7'd127;
	parameter logic [3:0] ExtBytes16 = 4'd2;
	parameter logic [3:0] ExtBytes64 = 4'd8;
	parameter logic [3:0] KeyBytes = 4'd4;
	parameter logic [3:0] BaseHdrBytes = 4'd2;

	// item kinds on the result side
	parameter logic KindHeader = 1'b0;
	parameter logic KindPayload = 1'b1;

	// decoupling queue
	parameter int QDepth = 4;
	parameter int QPtrW = 2;
	parameter logic [QPtrW:0] QFullCount = 3'd4;

	typedef enum logic [4:0] {
		PH_CTRL = 5'b00001,
		PH_INFO = 5'b00010,
		PH_LEN  = 5'b00100,
		PH_KEY  = 5'b01000,
		PH_DATA = 5'b10000
	} phase_t;

	// one queued operation for the back end
	typedef struct packed {
		logic        kind;
		logic [7:0]  ctrl;
		logic        masked;
		logic [63:0] length;
		logic [31:0] key;
		logic [3:0]  hdr_size;
		logic [7:0]  data;
		logic [7:0]  key_byte;
		logic        last;
	} entry_t;

	// header byte count for a given info byte
	function automatic logic [3:0] hdr_size(input logic [7:0] info);
		logic [3:0] ext;
		logic [3:0] key;
		begin
			if (info[6:0] == LenCode64) ext = ExtBytes64;
			else if (info[6:0] == LenCode16) ext = ExtBytes16;
			else ext = 4'd0;
			key = info[7] ? KeyBytes : 4'd0;
			return BaseHdrBytes + ext + key;
		end
	endfunction

endpackage

/* design/wsd_front.sv */
// ----------------------------------------------------------------------------
// wsd_front
// Header parser: takes one byte per cycle while the queue has room, tracks the frame
// phase and pushes header summaries and payload bytes (with their key byte) into it.
// ----------------------------------------------------------------------------
module wsd_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	input  logic [7:0]           in_byte,
	input  logic                 q_full,
	output logic                 push,
	output wsd_pkg::entry_t      push_entry
);

	wsd_pkg::phase_t phase_q;
	logic [3:0]  fc_q;
	logic [7:0]  ctrl_q;
	logic [7:0]  info_q;
	logic [63:0] len_q;
	logic [31:0] key_q;
	logic [63:0] left_q;
	logic [1:0]  ki_q;

	logic        acc;
	logic        short_in;
	logic [3:0]  cnt_inc;
	logic [3:0]  ext_need;
	logic        len_done;
	logic        key_done;
	logic [63:0] len_next;
	logic [31:0] key_next;
	logic        hdr_fire;
	logic [63:0] hdr_len;
	logic [31:0] hdr_key;
	logic [7:0]  hdr_info;
	logic        hdr_zero;
	logic        data_last;
	logic [7:0]  key_byte;

	assign acc      = byte_valid & ~q_full;
	assign short_in = (in_byte[6:0] != wsd_pkg::LenCode16) &&
	                  (in_byte[6:0] != wsd_pkg::LenCode64);
	assign cnt_inc  = fc_q + 4'd1;
	assign ext_need = (info_q[6:0] == wsd_pkg::LenCode64) ? wsd_pkg::ExtBytes64
	                                                      : wsd_pkg::ExtBytes16;
	assign len_done = cnt_inc >= ext_need;
	assign key_done = cnt_inc >= wsd_pkg::KeyBytes;
	assign len_next = {len_q[55:0], in_byte};
	assign key_next = {key_q[23:0], in_byte};
	assign data_last = (left_q == 64'd1);

	always_comb begin
		unique case (ki_q)
			2'd0: key_byte = key_q[31:24];
			2'd1: key_byte = key_q[23:16];
			2'd2: key_byte = key_q[15:8];
			2'd3: key_byte = key_q[7:0];
			default: key_byte = key_q[7:0];
		endcase
	end

	// which header byte, if any, closes the header
	always_comb begin
		hdr_fire = 1'b0;
		hdr_len  = len_q;
		hdr_key  = key_q;
		hdr_info = info_q;
		unique case (phase_q)
			wsd_pkg::PH_INFO: begin
				hdr_fire = short_in & ~in_byte[7];
				hdr_len  = {57'd0, in_byte[6:0]};
				hdr_key  = 32'd0;
				hdr_info = in_byte;
			end
			wsd_pkg::PH_LEN: begin
				hdr_fire = len_done & ~info_q[7];
				hdr_len  = len_next;
			end
			wsd_pkg::PH_KEY: begin
				hdr_fire = key_done;
				hdr_key  = key_next;
			end
			default: hdr_fire = 1'b0;
		endcase
	end

	assign hdr_zero = (hdr_len == 64'd0);

	always_comb begin
		push_entry = '0;
		if (phase_q == wsd_pkg::PH_DATA) begin
			push_entry.kind     = wsd_pkg::KindPayload;
			push_entry.data     = in_byte;
			push_entry.key_byte = key_byte;
			push_entry.last     = data_last;
		end else begin
			push_entry.kind     = wsd_pkg::KindHeader;
			push_entry.ctrl     = ctrl_q;
			push_entry.masked   = hdr_info[7];
			push_entry.length   = hdr_len;
			push_entry.key      = hdr_key;
			push_entry.hdr_size = wsd_pkg::hdr_size(hdr_info);
			push_entry.last     = hdr_zero;
		end
	end

	assign push = acc & (hdr_fire | (phase_q == wsd_pkg::PH_DATA));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= wsd_pkg::PH_CTRL;
			fc_q    <= 4'd0;
			ctrl_q  <= 8'd0;
			info_q  <= 8'd0;
			len_q   <= 64'd0;
			key_q   <= 32'd0;
			left_q  <= 64'd0;
			ki_q    <= 2'd0;
		end else if (acc) begin
			unique case (phase_q)
				wsd_pkg::PH_INFO: begin
					info_q <= in_byte;
					key_q  <= 32'd0;
					fc_q   <= 4'd0;
					if (short_in) begin
						len_q <= {57'd0, in_byte[6:0]};
						if (in_byte[7]) phase_q <= wsd_pkg::PH_KEY;
					end else begin
						len_q   <= 64'd0;
						phase_q <= wsd_pkg::PH_LEN;
					end
				end
				wsd_pkg::PH_LEN: begin
					len_q <= len_next;
					fc_q  <= cnt_inc;
					if (len_done) begin
						fc_q <= 4'd0;
						if (info_q[7]) phase_q <= wsd_pkg::PH_KEY;
					end
				end
				wsd_pkg::PH_KEY: begin
					key_q <= key_next;
					fc_q  <= key_done ? 4'd0 : cnt_inc;
				end
				wsd_pkg::PH_DATA: begin
					ki_q   <= ki_q + 2'd1;
					left_q <= left_q - 64'd1;
					if (data_last) phase_q <= wsd_pkg::PH_CTRL;
				end
				default: begin
					ctrl_q  <= in_byte;
					fc_q    <= 4'd0;
					phase_q <= wsd_pkg::PH_INFO;
				end
			endcase
			// header close overrides the phase step above
			if (hdr_fire) begin
				ki_q    <= 2'd0;
				left_q  <= hdr_len;
				phase_q <= hdr_zero ? wsd_pkg::PH_CTRL : wsd_pkg::PH_DATA;
			end
		end
	end

endmodule

/* design/wsd_queue.sv */
// ----------------------------------------------------------------------------
// wsd_queue
// Short register queue between the header parser and the result stage.
// ----------------------------------------------------------------------------
module wsd_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  wsd_pkg::entry_t      push_entry,
	input  logic                 pop,
	output logic                 full,
	output logic                 empty,
	output wsd_pkg::entry_t      head
);

	wsd_pkg::entry_t slot_q [wsd_pkg::QDepth];
	logic [wsd_pkg::QPtrW-1:0] wr_q;
	logic [wsd_pkg::QPtrW-1:0] rd_q;
	logic [wsd_pkg::QPtrW:0]   cnt_q;

	assign full  = (cnt_q == wsd_pkg::QFullCount);
	assign empty = (cnt_q == '0);
	assign head  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("wsd_queue: push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("wsd_queue: pop while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= wsd_pkg::QFullCount)
		else $error("wsd_queue: count beyond depth");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("wsd_queue: count did not follow push");
`endif

endmodule

/* design/wsd_back.sv */
// ----------------------------------------------------------------------------
// wsd_back
// Result stage: unmasks payload bytes, formats result fields and holds them
// in an output register.
// ----------------------------------------------------------------------------
module wsd_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 empty,
	input  wsd_pkg::entry_t      head,
	output logic                 pop,
	output logic                 item_valid,
	input  logic                 item_stall,
	output logic                 item_kind,
	output logic                 fin,
	output logic [2:0]           rsv_bits,
	output logic [3:0]           opcode,
	output logic                 masked,
	output logic [63:0]          payload_length,
	output logic [31:0]          mask_word,
	output logic [3:0]           header_size,
	output logic [7:0]           payload_byte,
	output logic                 last
);

	logic        valid_q;
	logic        kind_q;
	logic        fin_q;
	logic [2:0]  rsv_q;
	logic [3:0]  op_q;
	logic        masked_q;
	logic [63:0] len_q;
	logic [31:0] key_q;
	logic [3:0]  hs_q;
	logic [7:0]  data_q;
	logic        last_q;
	logic        is_hdr;

	assign pop    = ~empty & (~valid_q | ~item_stall);
	assign is_hdr = (head.kind == wsd_pkg::KindHeader);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else valid_q <= pop | (valid_q & item_stall);
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q   <= head.kind;
			fin_q    <= is_hdr & head.ctrl[7];
			rsv_q    <= is_hdr ? head.ctrl[6:4] : 3'd0;
			op_q     <= is_hdr ? head.ctrl[3:0] : 4'd0;
			masked_q <= is_hdr & head.masked;
			len_q    <= is_hdr ? head.length : 64'd0;
			key_q    <= is_hdr ? head.key : 32'd0;
			hs_q     <= is_hdr ? head.hdr_size : 4'd0;
			data_q   <= is_hdr ? 8'd0 : (head.data ^ head.key_byte);
			last_q   <= head.last;
		end
	end

	assign item_valid     = valid_q;
	assign item_kind      = kind_q;
	assign fin            = fin_q;
	assign rsv_bits       = rsv_q;
	assign opcode         = op_q;
	assign masked         = masked_q;
	assign payload_length = len_q;
	assign mask_word      = key_q;
	assign header_size    = hs_q;
	assign payload_byte   = data_q;
	assign last           = last_q;

endmodule

/* design/websocket_frame_deframer.sv */
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Parses a byte stream of back-to-back WebSocket frames into one header
// summary per frame followed by the unmasked payload bytes.
// ----------------------------------------------------------------------------
//
//  channel   | valid       | stall       | payload
//  ----------+-------------+-------------+-----------------------------------
//  byte in   | byte_valid  | byte_stall  | in_byte
//  item out  | item_valid  | item_stall  | item_kind .. last (ten fields)
//
//  One byte is taken per cycle while the parser queue has room.
//  A result passes through the queue, written at the edge that takes its byte,
//  and then through the output register before it is on the output.
//  Header bytes other than the last give no result.
//  A four-entry queue lets the parser run on while the output is stalled;
//  byte_stall rises only when that queue is full.
//  arst_n clears the parse phase, counters and all valid flags at once.
//
module websocket_frame_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  in_byte,
	output logic        item_valid,
	input  logic        item_stall,
	output logic        item_kind,
	output logic        fin,
	output logic [2:0]  rsv_bits,
	output logic [3:0]  opcode,
	output logic        masked,
	output logic [63:0] payload_length,
	output logic [31:0] mask_word,
	output logic [3:0]  header_size,
	output logic [7:0]  payload_byte,
	output logic        last
);

	// parser -> queue
	logic            push;
	wsd_pkg::entry_t push_entry;
	logic            q_full;

	// queue -> result stage
	logic            q_empty;
	logic            pop;
	wsd_pkg::entry_t head;

	// a byte transaction completes only when the queue can take its result
	assign byte_stall = q_full;

	// front: phase tracking, length/key assembly, key byte selection
	wsd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.in_byte    (in_byte),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	// decoupling queue
	wsd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (q_full),
		.empty      (q_empty),
		.head       (head)
	);

	// back: XOR unmasking, field formatting, output register
	wsd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.empty          (q_empty),
		.head           (head),
		.pop            (pop),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.item_kind      (item_kind),
		.fin            (fin),
		.rsv_bits       (rsv_bits),
		.opcode         (opcode),
		.masked         (masked),
		.payload_length (payload_length),
		.mask_word      (mask_word),
		.header_size    (header_size),
		.payload_byte   (payload_byte),
		.last           (last)
	);

endmodule

/* verif/websocket_frame_deframer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer_tb
// Feeds back-to-back WebSocket frames into the deframer one byte at a time.
// A parser model runs in step with every accepted byte and queues the header
// summary and unmasked payload bytes it expects. A monitor compares every
// output transaction field by field. Both sides idle at random, the output
// is held off long enough to back up the input, and the run ends at line rate
// with a frame whose 64-bit length has its top bit set.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_tb;

	// one output transaction, as the parser model sees it
	typedef struct packed {
		logic        kind;
		logic        fin;
		logic [2:0]  rsv;
		logic [3:0]  opcode;
		logic        masked;
		logic [63:0] length;
		logic [31:0] key;
		logic [3:0]  hdr_size;
		logic [7:0]  data;
		logic        last;
	} ws_item_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        byte_valid;
	logic        byte_stall;
	logic [7:0]  in_byte;
	logic        item_valid;
	logic        item_stall;
	logic        item_kind;
	logic        fin;
	logic [2:0]  rsv_bits;
	logic [3:0]  opcode;
	logic        masked;
	logic [63:0] payload_length;
	logic [31:0] mask_word;
	logic [3:0]  header_size;
	logic [7:0]  payload_byte;
	logic        last;

	// pacing controls shared by the test tasks and the receiver
	bit tx_gaps = 1'b1;
	bit rx_gaps = 1'b1;
	bit hold_output = 1'b0;
	localparam int HoldCycles = 50;

	int errors = 0;
	int bytes_sent = 0;

	// parser model state, same reset values as the block
	wsd_pkg::phase_t ph_q = wsd_pkg::PH_CTRL;
	logic [3:0]  cnt_q = '0;
	logic [7:0]  ctrl_q = '0;
	logic [7:0]  info_q = '0;
	logic [63:0] len_q = '0;
	logic [31:0] key_q = '0;
	logic [63:0] left_q = '0;
	logic [1:0]  key_idx = '0;

	// transactions the parser model says are still to come out
	ws_item_t parsed_items_q[$];

	websocket_frame_deframer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.in_byte(in_byte),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item_kind(item_kind),
		.fin(fin),
		.rsv_bits(rsv_bits),
		.opcode(opcode),
		.masked(masked),
		.payload_length(payload_length),
		.mask_word(mask_word),
		.header_size(header_size),
		.payload_byte(payload_byte),
		.last(last)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Parser model
	// ------------------------------------------------------------------

	// extended length bytes that follow an info byte: 0, 2 or 8
	function automatic logic [3:0] ext_bytes(input logic [7:0] info);
		if (info[6:0] == wsd_pkg::LenCode64) return wsd_pkg::ExtBytes64;
		if (info[6:0] == wsd_pkg::LenCode16) return wsd_pkg::ExtBytes16;
		return 4'd0;
	endfunction

	// last header byte seen: queue the summary and arm the payload count
	task automatic close_header();
		ws_item_t r;
		r = '0;
		r.kind = wsd_pkg::KindHeader;
		r.fin = ctrl_q[7];
		r.rsv = ctrl_q[6:4];
		r.opcode = ctrl_q[3:0];
		r.masked = info_q[7];
		r.length = len_q;
		r.key = key_q;
		r.hdr_size = wsd_pkg::BaseHdrBytes + ext_bytes(info_q) +
			(info_q[7] ? wsd_pkg::KeyBytes : 4'd0);
		cnt_q = '0;
		key_idx = '0;
		// an empty frame closes on its header, next byte is a control byte
		if (len_q == '0) begin
			r.last = 1'b1;
			left_q = '0;
			ph_q = wsd_pkg::PH_CTRL;
		end else begin
			left_q = len_q;
			ph_q = wsd_pkg::PH_DATA;
		end
		parsed_items_q.push_back(r);
	endtask

	task automatic length_done();
		cnt_q = '0;
		if (info_q[7]) ph_q = wsd_pkg::PH_KEY;
		else close_header();
	endtask

	// advance the model by one accepted byte
	task automatic parse_byte(input logic [7:0] b);
		ws_item_t r;
		logic [7:0] kb;
		case (ph_q)
			wsd_pkg::PH_INFO: begin
				info_q = b;
				key_q = '0;
				cnt_q = '0;
				if (ext_bytes(b) == 4'd0) begin
					len_q = {57'd0, b[6:0]};
					length_done();
				end else begin
					len_q = '0;
					ph_q = wsd_pkg::PH_LEN;
				end
			end
			wsd_pkg::PH_LEN: begin
				// big-endian, and a non-minimal length is taken as it is
				len_q = {len_q[55:0], b};
				cnt_q = cnt_q + 4'd1;
				if (cnt_q >= ext_bytes(info_q)) length_done();
			end
			wsd_pkg::PH_KEY: begin
				key_q = {key_q[23:0], b};
				cnt_q = cnt_q + 4'd1;
				if (cnt_q >= wsd_pkg::KeyBytes) close_header();
			end
			wsd_pkg::PH_DATA: begin
				// first key byte on the wire sits in the top of the word
				kb = key_q[(3 - key_idx) * 8 +: 8];
				r = '0;
				r.kind = wsd_pkg::KindPayload;
				r.data = b ^ kb;
				key_idx = key_idx + 2'd1;
				left_q = left_q - 64'd1;
				if (left_q == '0) begin
					r.last = 1'b1;
					ph_q = wsd_pkg::PH_CTRL;
				end
				parsed_items_q.push_back(r);
			end
			default: begin
				ctrl_q = b;
				cnt_q = '0;
				ph_q = wsd_pkg::PH_INFO;
			end
		endcase
	endtask

	// ------------------------------------------------------------------
	// Byte side
	// ------------------------------------------------------------------

	// offer one byte, wait for the transaction, then step the model;
	// entered and left at a rising edge
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (tx_gaps && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 15);
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_valid <= 1'b1;
		in_byte <= b;
		@(posedge clk);
		while (byte_stall) @(posedge clk);
		parse_byte(b);
		bytes_sent++;
	endtask

	// one frame on the wire; body is how many payload bytes actually go out,
	// which only falls short of len for the oversized frame at the end
	task automatic send_frame(input logic [7:0] ctrl, input bit use_key,
			input logic [6:0] code, input logic [63:0] len,
			input logic [31:0] key, input int body);
		send_byte(ctrl);
		send_byte({use_key, code});
		if (code == wsd_pkg::LenCode16) begin
			send_byte(len[15:8]);
			send_byte(len[7:0]);
		end else if (code == wsd_pkg::LenCode64) begin
			for (int i = 7; i >= 0; i--) send_byte(len[i * 8 +: 8]);
		end
		if (use_key)
			for (int i = 3; i >= 0; i--) send_byte(key[i * 8 +: 8]);
		for (int i = 0; i < body; i++) send_byte(8'($urandom_range(0, 255)));
	endtask

	// random frame, short payloads mostly, every length code in play
	task automatic random_frame();
		int sel;
		logic [6:0] code;
		logic [63:0] len;
		sel = $urandom_range(0, 99);
		if (sel < 55) begin
			len = 64'($urandom_range(0, 8));
			code = len[6:0];
		end else if (sel < 65) begin
			len = 64'($urandom_range(9, 30));
			code = len[6:0];
		end else if (sel < 69) begin
			len = 64'($urandom_range(31, 125));
			code = len[6:0];
		end else if (sel < 84) begin
			code = wsd_pkg::LenCode16;
			len = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(126, 300))
			                                  : 64'($urandom_range(0, 24));
		end else begin
			code = wsd_pkg::LenCode64;
			len = 64'($urandom_range(0, 24));
		end
		send_frame(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), code, len,
			$urandom, int'(len));
	endtask

	// ------------------------------------------------------------------
	// Receiver pacing: random stall bursts, or one long hold on request
	// ------------------------------------------------------------------
	initial begin : rx_pacing
		int n;
		item_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_output) begin
				item_stall <= 1'b1;
				repeat (HoldCycles) @(posedge clk);
				hold_output = 1'b0;
				item_stall <= 1'b0;
			end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 15);
				item_stall <= 1'b1;
				repeat (n) @(posedge clk);
				item_stall <= 1'b0;
			end else begin
				item_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result monitor
	// ------------------------------------------------------------------
	task automatic check_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, actual %0h", name, exp_v, act_v);
			errors++;
		end
	endtask

	// inputs and outputs are read before this edge updates them
	always @(posedge clk) begin : result_monitor
		ws_item_t want;
		if (arst_n && item_valid && !item_stall) begin
			if (parsed_items_q.size() == 0) begin
				$error("output transaction with nothing outstanding");
				errors++;
			end else begin
				want = parsed_items_q.pop_front();
				check_field("item_kind", 64'(want.kind), 64'(item_kind));
				check_field("fin", 64'(want.fin), 64'(fin));
				check_field("rsv_bits", 64'(want.rsv), 64'(rsv_bits));
				check_field("opcode", 64'(want.opcode), 64'(opcode));
				check_field("masked", 64'(want.masked), 64'(masked));
				check_field("payload_length", want.length, payload_length);
				check_field("mask_word", 64'(want.key), 64'(mask_word));
				check_field("header_size", 64'(want.hdr_size), 64'(header_size));
				check_field("payload_byte", 64'(want.data), 64'(payload_byte));
				check_field("last", 64'(want.last), 64'(last));
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// hand-built frames: empty frames with and without key, all control
	// bits set and clear, both extended codes with non-minimal lengths
	task automatic test_directed_headers();
		send_frame(8'hFF, 1'b0, 7'd0, 64'd0, 32'd0, 0);
		send_frame(8'h00, 1'b1, 7'd0, 64'd0, 32'hA55A_FF00, 0);
		send_frame(8'h81, 1'b1, 7'd3, 64'd3, 32'hFFFF_FFFF, 3);
		send_frame(8'h82, 1'b0, wsd_pkg::LenCode16, 64'd2, 32'd0, 2);
		send_frame(8'h7A, 1'b1, wsd_pkg::LenCode64, 64'd1, 32'h0123_4567, 1);
		send_frame(8'h09, 1'b0, wsd_pkg::LenCode64, 64'd0, 32'd0, 0);
	endtask

	task automatic test_random_frames();
		while (bytes_sent < 820) random_frame();
	endtask

	// hold the output off while a long masked frame streams in, so the
	// internal queue fills and the byte side stalls
	task automatic test_output_hold();
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		hold_output = 1'b1;
		send_frame(8'h82, 1'b1, 7'd60, 64'd60, $urandom, 60);
	endtask

	task automatic test_line_rate();
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		while (bytes_sent < 1020) random_frame();
	endtask

	// all-ones 64-bit length: top bit set, taken in full; the stream ends
	// partway through its payload, which reset is never used to clear
	task automatic test_giant_length();
		send_frame(8'hC1, 1'b1, wsd_pkg::LenCode64, 64'hFFFF_FFFF_FFFF_FFFF,
			32'h5AA5_C33C, 20);
	endtask

	initial begin
		arst_n = 1'b0;
		byte_valid = 1'b0;
		in_byte = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_headers();
		test_random_frames();
		test_output_hold();
		test_line_rate();
		test_giant_length();

		byte_valid <= 1'b0;
		while (parsed_items_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (parsed_items_q.size() == 0 && errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// safety net against a hung handshake
	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

/* filelist.f */
design/wsd_pkg.sv
design/wsd_front.sv
design/wsd_queue.sv
design/wsd_back.sv
design/websocket_frame_deframer.sv
verif/websocket_frame_deframer_tb.sv
